@@ rtl/mvdi_pkg.sv @@
// Shared constants and types for the mesh vertex dedup indexer.
package mvdi_pkg;

   localparam int VERTEX_DEPTH  = 256;
   localparam int SEGMENT_DEPTH = 256;
   localparam int COORD_WIDTH   = 32;

   localparam int VIDX_W = $clog2(VERTEX_DEPTH);
   localparam int VCNT_W = $clog2(VERTEX_DEPTH + 1);
   localparam int SIDX_W = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
   localparam int SCNT_W = $clog2(SEGMENT_DEPTH + 1);

   localparam int IN_W       = 32;
   localparam int INDEX_W    = 8;
   localparam int HELD_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z = 2'd2;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] z;
   } point_type;

   typedef struct packed {
      logic      go;
      point_type s_pt;
      point_type e_pt;
      logic      seg_full;
   } vt_cmd_type;

   typedef struct packed {
      logic              done;
      logic              stored;
      logic              full;
      logic              from_added;
      logic              to_added;
      logic [VIDX_W-1:0] from_idx;
      logic [VIDX_W-1:0] to_idx;
   } vt_rsp_type;

endpackage

@@ rtl/mvdi_vertex_table.sv @@
// Vertex memory with in-order lookup scan and append of missing points.
module mvdi_vertex_table
   import mvdi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  vt_cmd_type cmd,
   output vt_rsp_type rsp
);

   typedef enum logic [3:0] {
      VS_IDLE   = 4'b0001,
      VS_SCAN   = 4'b0010,
      VS_DECIDE = 4'b0100,
      VS_APPEND = 4'b1000
   } vs_state_type;

   point_type mem [VERTEX_DEPTH];

   vs_state_type      state_ff, state_in;
   logic [VCNT_W-1:0] total_ff, total_in;
   logic [VCNT_W-1:0] ra_ff, ra_in;
   logic              rv_ff, rv_in;
   logic [VIDX_W-1:0] ri_ff, ri_in;
   logic              hf_ff, hf_in, ht_ff, ht_in;
   logic              fa_ff, fa_in;
   logic [VIDX_W-1:0] fi_ff, fi_in, ti_ff, ti_in;
   vt_rsp_type        rsp_ff, rsp_in;
   point_type         rd_data_ff;

   logic              wr_en;
   logic [VIDX_W-1:0] wr_addr;
   point_type         wr_data;
   logic [1:0]        need;
   logic [VCNT_W:0]   total_need;
   logic              full;
   logic              both;
   logic              last;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      ra_in    = ra_ff;
      rv_in    = 1'b0;
      ri_in    = ri_ff;
      hf_in    = hf_ff;
      ht_in    = ht_ff;
      fa_in    = fa_ff;
      fi_in    = fi_ff;
      ti_in    = ti_ff;
      rsp_in   = '0;
      wr_en    = 1'b0;
      wr_addr  = total_ff[VIDX_W-1:0];
      wr_data  = cmd.s_pt;
      both     = 1'b0;
      last     = 1'b0;
      need       = {1'b0, ~hf_ff} + {1'b0, ~ht_ff};
      total_need = {1'b0, total_ff} + (VCNT_W+1)'(need);
      full       = (total_need > (VCNT_W+1)'(VERTEX_DEPTH)) || cmd.seg_full;

      unique case (state_ff)
         VS_IDLE: begin
            if (cmd.go) begin
               ra_in    = '0;
               hf_in    = 1'b0;
               ht_in    = 1'b0;
               fa_in    = 1'b0;
               state_in = VS_SCAN;
            end
         end
         VS_SCAN: begin
            if (rv_ff) begin
               if (!hf_ff && rd_data_ff == cmd.s_pt) begin
                  hf_in = 1'b1;
                  fi_in = ri_ff;
               end else if (!ht_ff && rd_data_ff == cmd.e_pt) begin
                  ht_in = 1'b1;
                  ti_in = ri_ff;
               end
            end
            both = hf_in && ht_in;
            last = ra_ff >= total_ff;
            if (both || last) begin
               state_in = VS_DECIDE;
            end else begin
               rv_in = 1'b1;
               ri_in = ra_ff[VIDX_W-1:0];
               ra_in = ra_ff + 1'b1;
            end
         end
         VS_DECIDE: begin
            if (full) begin
               rsp_in.done = 1'b1;
               rsp_in.full = 1'b1;
               state_in    = VS_IDLE;
            end else begin
               if (!hf_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = cmd.s_pt;
                  fi_in    = total_ff[VIDX_W-1:0];
                  total_in = total_ff + 1'b1;
                  fa_in    = 1'b1;
               end
               state_in = VS_APPEND;
            end
         end
         VS_APPEND: begin
            if (!ht_ff) begin
               wr_en    = 1'b1;
               wr_data  = cmd.e_pt;
               ti_in    = total_ff[VIDX_W-1:0];
               total_in = total_ff + 1'b1;
            end
            rsp_in.done       = 1'b1;
            rsp_in.stored     = 1'b1;
            rsp_in.from_added = fa_ff;
            rsp_in.to_added   = !ht_ff;
            rsp_in.from_idx   = fi_ff;
            rsp_in.to_idx     = ti_in;
            state_in          = VS_IDLE;
         end
         default: begin
            state_in = VS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ra_ff[VIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VS_IDLE;
         total_ff <= '0;
         rv_ff    <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rv_ff    <= rv_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      ri_ff <= ri_in;
      hf_ff <= hf_in;
      ht_ff <= ht_in;
      fa_ff <= fa_in;
      fi_ff <= fi_in;
      ti_ff <= ti_in;
   end

   assign rsp = rsp_ff;

endmodule

@@ rtl/mesh_vertex_dedup_indexer_core.sv @@
// Top level of the mesh vertex dedup indexer: command port, offsets, segment table.
//
// Usage: drive the six point coordinates on req_* and raise start while busy is
// low; the word is taken at that clock edge. Offsets are written through the
// csr_* port (index 0..2 for x, y, z) while the block is idle; writes take
// effect at once and cannot be read back.
// Each word yields exactly one result, shown on rsp_* for one cycle with
// rsp_valid high. The receiver cannot stall, so results are never held.
// An all-zero segment (end marker) answers in the cycle after acceptance and
// busy never rises. Any other segment scans the vertex memory in insertion
// order, one read per cycle, through the single read port of the vertex memory.
// A hit on both endpoints ends the scan early. busy falls in the cycle the
// result is shown, and a new word may be started in that cycle.
// Reset (synchronous, active high) clears the vertex and segment counts and
// the offsets; memory contents are not cleared and need no clearing pass.
module mesh_vertex_dedup_indexer_core
   import mvdi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [IN_W-1:0]       req_start_x,
   input  logic [IN_W-1:0]       req_start_y,
   input  logic [IN_W-1:0]       req_start_z,
   input  logic [IN_W-1:0]       req_end_x,
   input  logic [IN_W-1:0]       req_end_y,
   input  logic [IN_W-1:0]       req_end_z,
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   output logic [INDEX_W-1:0]    rsp_from_index,
   output logic [INDEX_W-1:0]    rsp_to_index,
   output logic                  rsp_from_added,
   output logic                  rsp_to_added,
   output logic                  rsp_table_full,
   output logic [HELD_W-1:0]     rsp_segments_held,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      TS_IDLE   = 2'b01,
      TS_LOOKUP = 2'b10
   } ts_state_type;

   logic [VIDX_W-1:0] seg_from_mem [SEGMENT_DEPTH];
   logic [VIDX_W-1:0] seg_to_mem   [SEGMENT_DEPTH];

   ts_state_type           state_ff, state_in;
   logic [COORD_WIDTH-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic [SCNT_W-1:0]      seg_total_ff, seg_total_in;
   point_type              s_pt_ff, s_pt_in, e_pt_ff, e_pt_in;
   logic                   go_ff, go_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               acc_ff, acc_in;
   logic [INDEX_W-1:0] fidx_ff, fidx_in, tidx_ff, tidx_in;
   logic               fadd_ff, fadd_in, tadd_ff, tadd_in;
   logic               full_ff, full_in;
   logic [HELD_W-1:0]  held_ff, held_in;

   logic       accept;
   logic       marker;
   point_type  raw_s, raw_e;
   logic       seg_wr;
   vt_cmd_type vt_cmd;
   vt_rsp_type vt_rsp;

   assign busy   = (state_ff == TS_LOOKUP);
   assign accept = start && !busy;

   assign raw_s.x = req_start_x[COORD_WIDTH-1:0];
   assign raw_s.y = req_start_y[COORD_WIDTH-1:0];
   assign raw_s.z = req_start_z[COORD_WIDTH-1:0];
   assign raw_e.x = req_end_x[COORD_WIDTH-1:0];
   assign raw_e.y = req_end_y[COORD_WIDTH-1:0];
   assign raw_e.z = req_end_z[COORD_WIDTH-1:0];
   assign marker  = ~|{raw_s, raw_e};

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OFFSET_X: off_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_OFFSET_Y: off_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_OFFSET_Z: off_z_ff <= csr_wdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign vt_cmd.go       = go_ff;
   assign vt_cmd.s_pt     = s_pt_ff;
   assign vt_cmd.e_pt     = e_pt_ff;
   assign vt_cmd.seg_full = seg_total_ff >= SCNT_W'(SEGMENT_DEPTH);

   mvdi_vertex_table u_vertex_table (
      .clock (clock),
      .reset (reset),
      .cmd   (vt_cmd),
      .rsp   (vt_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      seg_total_in = seg_total_ff;
      s_pt_in      = s_pt_ff;
      e_pt_in      = e_pt_ff;
      go_in        = 1'b0;
      seg_wr       = 1'b0;
      rsp_valid_in = 1'b0;
      acc_in       = 1'b0;
      fidx_in      = '0;
      tidx_in      = '0;
      fadd_in      = 1'b0;
      tadd_in      = 1'b0;
      full_in      = 1'b0;
      held_in      = HELD_W'(seg_total_ff);

      unique case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               s_pt_in.x = raw_s.x + off_x_ff;
               s_pt_in.y = raw_s.y + off_y_ff;
               s_pt_in.z = raw_s.z + off_z_ff;
               e_pt_in.x = raw_e.x + off_x_ff;
               e_pt_in.y = raw_e.y + off_y_ff;
               e_pt_in.z = raw_e.z + off_z_ff;
               if (marker) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  go_in    = 1'b1;
                  state_in = TS_LOOKUP;
               end
            end
         end
         TS_LOOKUP: begin
            if (vt_rsp.done) begin
               rsp_valid_in = 1'b1;
               full_in      = vt_rsp.full;
               if (vt_rsp.stored) begin
                  seg_wr       = 1'b1;
                  seg_total_in = seg_total_ff + 1'b1;
                  acc_in       = 1'b1;
                  fidx_in      = INDEX_W'(vt_rsp.from_idx);
                  tidx_in      = INDEX_W'(vt_rsp.to_idx);
                  fadd_in      = vt_rsp.from_added;
                  tadd_in      = vt_rsp.to_added;
                  held_in      = HELD_W'(seg_total_in);
               end
               state_in = TS_IDLE;
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (seg_wr) begin
         seg_from_mem[seg_total_ff[SIDX_W-1:0]] <= vt_rsp.from_idx;
         seg_to_mem[seg_total_ff[SIDX_W-1:0]]   <= vt_rsp.to_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         seg_total_ff <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_total_ff <= seg_total_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_pt_ff <= s_pt_in;
      e_pt_ff <= e_pt_in;
      acc_ff  <= acc_in;
      fidx_ff <= fidx_in;
      tidx_ff <= tidx_in;
      fadd_ff <= fadd_in;
      tadd_ff <= tadd_in;
      full_ff <= full_in;
      held_ff <= held_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_from_index    = fidx_ff;
   assign rsp_to_index      = tidx_ff;
   assign rsp_from_added    = fadd_ff;
   assign rsp_to_added      = tadd_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_segments_held = held_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while lookup still running");

   a_store_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_table_full))
      else $error("word both stored and rejected as full");

   a_vt_done_in_lookup: assert property (@(posedge clock) disable iff (reset)
      vt_rsp.done |-> state_ff == TS_LOOKUP)
      else $error("vertex table answered with no lookup pending");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      seg_total_ff <= SCNT_W'(SEGMENT_DEPTH))
      else $error("segment count past table depth");

endmodule

@@ test/tb_mesh_vertex_dedup_indexer_core.sv @@
// Self-checking testbench for mesh_vertex_dedup_indexer_core: directed and random segments.
module tb_mesh_vertex_dedup_indexer_core;
   import mvdi_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic               accepted;
      logic [INDEX_W-1:0] from_index;
      logic [INDEX_W-1:0] to_index;
      logic               from_added;
      logic               to_added;
      logic               table_full;
      logic [HELD_W-1:0]  segments_held;
   } seg_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [IN_W-1:0]       req_start_x;
   logic [IN_W-1:0]       req_start_y;
   logic [IN_W-1:0]       req_start_z;
   logic [IN_W-1:0]       req_end_x;
   logic [IN_W-1:0]       req_end_y;
   logic [IN_W-1:0]       req_end_z;
   logic                  rsp_valid;
   logic                  rsp_accepted;
   logic [INDEX_W-1:0]    rsp_from_index;
   logic [INDEX_W-1:0]    rsp_to_index;
   logic                  rsp_from_added;
   logic                  rsp_to_added;
   logic                  rsp_table_full;
   logic [HELD_W-1:0]     rsp_segments_held;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   point_type   vtx_table [VERTEX_DEPTH];
   int          vtx_count = 0;
   int          seg_count = 0;
   logic [31:0] off_x = '0;
   logic [31:0] off_y = '0;
   logic [31:0] off_z = '0;

   seg_result_type expected_results[$];
   int errors = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int n_sent = 0;
   int n_stored = 0;
   int n_full = 0;
   int n_marker = 0;

   mesh_vertex_dedup_indexer_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_start_z       (req_start_z),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_end_z         (req_end_z),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_from_index    (rsp_from_index),
      .rsp_to_index      (rsp_to_index),
      .rsp_from_added    (rsp_from_added),
      .rsp_to_added      (rsp_to_added),
      .rsp_table_full    (rsp_table_full),
      .rsp_segments_held (rsp_segments_held),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mesh_vertex_dedup_indexer_core: done, errors");
         $finish;
      end
   end

   function automatic point_type shift_point(point_type p);
      point_type q;
      q.x = p.x + off_x;
      q.y = p.y + off_y;
      q.z = p.z + off_z;
      return q;
   endfunction

   // Dedup lookup, append and segment store; updates the tracked tables.
   function automatic seg_result_type index_segment(point_type s_in, point_type e_in);
      seg_result_type r;
      point_type   s;
      point_type   e;
      bit          have_from;
      bit          have_to;
      int          from_i;
      int          to_i;
      int          need;
      r = '0;
      have_from = 1'b0;
      have_to = 1'b0;
      from_i = 0;
      to_i = 0;
      if ({s_in, e_in} == '0) begin
         r.segments_held = seg_count[HELD_W-1:0];
         return r;
      end
      s = shift_point(s_in);
      e = shift_point(e_in);
      for (int i = 0; i < vtx_count; i++) begin
         if (!have_from && vtx_table[i] == s) begin
            have_from = 1'b1;
            from_i = i;
         end else if (!have_to && vtx_table[i] == e) begin
            have_to = 1'b1;
            to_i = i;
         end
         if (have_from && have_to) break;
      end
      need = (have_from ? 0 : 1) + (have_to ? 0 : 1);
      if (vtx_count + need > VERTEX_DEPTH || seg_count >= SEGMENT_DEPTH) begin
         r.table_full = 1'b1;
         r.segments_held = seg_count[HELD_W-1:0];
         return r;
      end
      if (!have_from) begin
         from_i = vtx_count;
         vtx_table[vtx_count] = s;
         vtx_count++;
         r.from_added = 1'b1;
      end
      if (!have_to) begin
         to_i = vtx_count;
         vtx_table[vtx_count] = e;
         vtx_count++;
         r.to_added = 1'b1;
      end
      seg_count++;
      r.accepted = 1'b1;
      r.from_index = from_i[INDEX_W-1:0];
      r.to_index = to_i[INDEX_W-1:0];
      r.segments_held = seg_count[HELD_W-1:0];
      return r;
   endfunction

   function automatic logic [IN_W-1:0] pick_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic point_type fresh_point();
      point_type p;
      p.x = pick_coord();
      p.y = pick_coord();
      p.z = pick_coord();
      return p;
   endfunction

   // Input that lands on a vertex already held, under the current offsets.
   function automatic point_type stored_point();
      point_type p;
      if (vtx_count == 0) return fresh_point();
      p = vtx_table[$urandom_range(vtx_count - 1)];
      p.x = p.x - off_x;
      p.y = p.y - off_y;
      p.z = p.z - off_z;
      return p;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      seg_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            errors++;
            $error("result word with no segment outstanding");
         end else begin
            want = expected_results.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("from_index", 32'(want.from_index), 32'(rsp_from_index));
            check_field("to_index", 32'(want.to_index), 32'(rsp_to_index));
            check_field("from_added", 32'(want.from_added), 32'(rsp_from_added));
            check_field("to_added", 32'(want.to_added), 32'(rsp_to_added));
            check_field("table_full", 32'(want.table_full), 32'(rsp_table_full));
            check_field("segments_held", 32'(want.segments_held),
                        32'(rsp_segments_held));
            if (want.accepted) n_stored++;
            else if (want.table_full) n_full++;
            else n_marker++;
         end
      end
   end

   task automatic send_segment(input point_type s, input point_type e);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_start_x <= s.x;
      req_start_y <= s.y;
      req_start_z <= s.z;
      req_end_x <= e.x;
      req_end_y <= e.y;
      req_end_z <= e.z;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      expected_results.push_back(index_segment(s, e));
      n_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_OFFSET_X: off_x = value;
         CSR_OFFSET_Y: off_y = value;
         CSR_OFFSET_Z: off_z = value;
         default: ;
      endcase
   endtask

   task automatic set_offsets(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      write_csr(CSR_OFFSET_X, x);
      write_csr(CSR_OFFSET_Y, y);
      write_csr(CSR_OFFSET_Z, z);
   endtask

   task automatic test_end_marker();
      send_segment('0, '0);
      wait_idle();
   endtask

   task automatic test_extremes_and_reuse();
      point_type a;
      point_type b;
      point_type c;
      a = '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'hFFFF_FFFF};
      b = '{x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'h0000_0001};
      c = '{x: 32'h0000_0001, y: 32'h0000_0002, z: 32'h0000_0003};
      send_segment(a, b);
      send_segment(b, a);
      send_segment('0, a);
      send_segment(a, '0);
      send_segment(c, c);
      send_segment(c, c);
      send_segment(c, c);
      send_segment(a, b);
      send_segment('0, '0);
      wait_idle();
   endtask

   task automatic test_offset_wrap();
      point_type one;
      point_type top;
      one = '{x: 32'h1, y: 32'h1, z: 32'h1};
      top = '{x: '1, y: '1, z: '1};
      set_offsets(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE, 32'hFFFF_FFFF);
      send_segment('0, one);
      send_segment('0, '0);
      send_segment(top, one);
      send_segment(one, '0);
      wait_idle();
   endtask

   task automatic test_random_mix(input int pct, input logic [31:0] ox,
                                  input logic [31:0] oy, input logic [31:0] oz,
                                  input int count);
      point_type s;
      point_type e;
      int        kind;
      set_offsets(ox, oy, oz);
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            s = '0;
            e = '0;
         end else if (kind < 45) begin
            s = fresh_point();
            e = fresh_point();
         end else if (kind < 70) begin
            if ($urandom_range(1)) begin
               s = stored_point();
               e = fresh_point();
            end else begin
               s = fresh_point();
               e = stored_point();
            end
         end else if (kind < 85) begin
            s = stored_point();
            e = stored_point();
         end else if (kind < 95) begin
            s = $urandom_range(1) ? stored_point() : fresh_point();
            e = s;
         end else begin
            s = '0;
            e = fresh_point();
            if ($urandom_range(1)) begin
               s = e;
               e = '0;
            end
         end
         send_segment(s, e);
      end
      wait_idle();
      idle_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_start_z = '0;
      req_end_x = '0;
      req_end_y = '0;
      req_end_z = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_end_marker();
      test_extremes_and_reuse();
      test_offset_wrap();
      test_random_mix(0, 32'h0, 32'h0, 32'h0, 75);
      test_random_mix(64, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 75);
      test_random_mix(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 75);
      test_random_mix(35, $urandom, $urandom, $urandom, 1611);

      repeat (300) @(posedge clock);
      $display("covered %0d segment words: %0d stored, %0d refused as full, %0d end markers",
               n_sent, n_stored, n_full, n_marker);
      $display("final tables: %0d vertices, %0d segments", vtx_count, seg_count);
      if (errors == 0) begin
         $display("tb_mesh_vertex_dedup_indexer_core: done, clean");
      end else begin
         $display("tb_mesh_vertex_dedup_indexer_core: done, errors");
      end
      $finish;
   end

endmodule

@@ mesh_vertex_dedup_indexer_core.f @@
rtl/mvdi_pkg.sv
rtl/mvdi_vertex_table.sv
rtl/mesh_vertex_dedup_indexer_core.sv
test/tb_mesh_vertex_dedup_indexer_core.sv
